@@ hw/rtl/sha256_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions of the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam logic [1:0] CMD_DATA    = 2'd0;
  localparam logic [1:0] CMD_FINISH  = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  localparam int BLOCK_BYTES = 64;
  localparam int ROUNDS      = 64;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  typedef logic [31:0] word_t;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  function automatic word_t init_h(input logic [2:0] i);
    word_t h [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                     32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

  function automatic word_t ror(input word_t v, input int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  // Control from sequencer to compression core
  typedef struct packed {
    logic start;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
  } core_sts_t;

endpackage

@@ hw/rtl/sha256_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_cmd_if / sha256_dig_if
// Valid/ready channels for command items and digest word items.
// ----------------------------------------------------------------------------
interface sha256_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;
  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

interface sha256_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ hw/rtl/sha256_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_core
// Compression engine: reads message words from the block buffer (registered-read
// memory), builds the schedule in a 16-word window and runs one round a cycle.
// Hash words live in an 8-entry memory, read and written back word by word.
// ----------------------------------------------------------------------------
module sha256_core (
  input  logic                    clk,
  input  logic                    rst,
  input  sha256_pkg::core_ctl_t   ctl,
  output sha256_pkg::core_sts_t   sts,
  output logic [3:0]              buf_raddr,
  input  sha256_pkg::word_t       buf_rdata,
  input  logic                    hash_reinit,
  input  logic [2:0]              hash_raddr,
  output sha256_pkg::word_t       hash_rdata
);

  localparam logic [2:0] S_IDLE = 3'd0, S_LOAD = 3'd1, S_ROUND = 3'd2,
                         S_ADD = 3'd3, S_INIT = 3'd4;

  logic [2:0] state;
  logic [6:0] cnt;
  sha256_pkg::word_t hmem [8];
  sha256_pkg::word_t hq;
  logic [2:0] haddr;
  logic       hwe;
  sha256_pkg::word_t hwd;
  sha256_pkg::word_t r [8];
  sha256_pkg::word_t w [16];
  sha256_pkg::word_t wt, s0, s1, t1, t2, e, a;
  logic [5:0] t;

  assign sts.busy = (state != S_IDLE);
  assign buf_raddr = cnt[3:0];
  assign hash_rdata = hq;
  // round index trails cnt by one: buffer read data is registered behind its address
  assign t = cnt[5:0] - 6'd1;

  always_comb begin
    s0 = sha256_pkg::ror(w[1], 7) ^ sha256_pkg::ror(w[1], 18) ^ (w[1] >> 3);
    s1 = sha256_pkg::ror(w[14], 17) ^ sha256_pkg::ror(w[14], 19) ^ (w[14] >> 10);
    wt = (t < 6'd16) ? buf_rdata : (w[0] + s0 + w[9] + s1);
    e = r[4];
    a = r[0];
    t1 = r[7] + (sha256_pkg::ror(e, 6) ^ sha256_pkg::ror(e, 11) ^ sha256_pkg::ror(e, 25)) +
         ((e & r[5]) ^ (~e & r[6])) + sha256_pkg::round_k(t) + wt;
    t2 = (sha256_pkg::ror(a, 2) ^ sha256_pkg::ror(a, 13) ^ sha256_pkg::ror(a, 22)) +
         ((a & r[1]) ^ (a & r[2]) ^ (r[1] & r[2]));
  end

  always_comb begin
    hwe = 1'b0;
    haddr = hash_raddr;
    hwd = hq + r[0];
    case (state)
      S_LOAD: haddr = cnt[2:0];
      S_ADD: begin
        haddr = cnt[2:0];
        hwe = (cnt != 7'd0);
      end
      S_INIT: begin
        haddr = cnt[2:0];
        hwe = 1'b1;
        hwd = sha256_pkg::init_h(cnt[2:0]);
      end
      default: ;
    endcase
  end

  // Write address trails the read address through a register in S_ADD; write uses registered address.
  logic [2:0] waddr;
  always_ff @(posedge clk) begin
    if (hwe) hmem[(state == S_INIT) ? haddr : waddr] <= hwd;
    hq <= hmem[haddr];
    waddr <= haddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (hash_reinit) state <= S_INIT;
          else if (ctl.start) state <= S_LOAD;
        end
        S_LOAD: begin
          // cnt 0..8: hash reads are registered in hq and land in r[cnt-1]
          if (cnt != 7'd0) r[cnt[2:0] - 3'd1] <= hq;
          if (cnt == 7'd8) begin
            cnt <= '0;
            state <= S_ROUND;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_ROUND: begin
          // buffer read issued at cnt, data valid at cnt+1: use offset
          if (cnt == 7'd64) begin
            cnt <= '0;
            state <= S_ADD;
          end else begin
            cnt <= cnt + 7'd1;
          end
          if (cnt != 7'd0) begin
            r[7] <= r[6]; r[6] <= r[5]; r[5] <= e; r[4] <= r[3] + t1;
            r[3] <= r[2]; r[2] <= r[1]; r[1] <= a; r[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
            w[15] <= wt;
          end
        end
        S_ADD: begin
          // shift window so r[0] pairs with next word read
          if (cnt != 7'd0) begin
            for (int i = 0; i < 7; i++) r[i] <= r[i + 1];
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'd8) state <= S_IDLE;
        end
        S_INIT: begin
          if (cnt[2:0] == 3'd7) begin
            cnt <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/sha256_stream_hasher_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// Data byte: written to the block buffer; the 64th byte of a block holds off input
// while the block is compressed.
// Finish: marker and padding written one byte a cycle (held while a block is
// compressed), one or two compressions, then eight digest items at the output register.
// Reset and restart reload the hash memory; no item is taken then.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top (
  input logic            clk,
  input logic            rst,
  sha256_cmd_if.sink     cmd,
  sha256_dig_if.source   dig
);

  localparam logic [2:0] Q_IDLE = 3'd0, Q_COMP = 3'd1, Q_PAD = 3'd2,
                         Q_EMIT = 3'd3, Q_WAIT = 3'd4;

  logic [2:0]  state;
  logic [5:0]  fill;
  logic [60:0] count;
  logic        done;
  logic        second;
  logic [2:0]  widx;
  logic        rd_pend;
  logic        last_pad;

  sha256_pkg::core_ctl_t ctl;
  sha256_pkg::core_sts_t sts;
  logic [3:0]  buf_raddr;
  sha256_pkg::word_t buf_rdata;
  logic        reinit;
  sha256_pkg::word_t hash_rdata;

  // block buffer: 16 x 32-bit words, byte lanes
  logic [7:0]  bmem0 [16], bmem1 [16], bmem2 [16], bmem3 [16];
  logic        bwe;
  logic [5:0]  bwa;
  logic [7:0]  bwd;
  logic [63:0] bits;

  assign bits = {count, 3'b000};

  always_ff @(posedge clk) begin
    if (bwe) begin
      case (bwa[1:0])
        2'd0: bmem0[bwa[5:2]] <= bwd;
        2'd1: bmem1[bwa[5:2]] <= bwd;
        2'd2: bmem2[bwa[5:2]] <= bwd;
        default: bmem3[bwa[5:2]] <= bwd;
      endcase
    end
    buf_rdata <= {bmem0[buf_raddr], bmem1[buf_raddr], bmem2[buf_raddr], bmem3[buf_raddr]};
  end

  sha256_core u_core (
    .clk, .rst, .ctl, .sts, .buf_raddr, .buf_rdata,
    .hash_reinit(reinit), .hash_raddr(widx), .hash_rdata
  );

  logic take;
  assign cmd.ready = (state == Q_IDLE) && !sts.busy && !ctl.start && !reinit;
  assign take = cmd.valid && cmd.ready;

  always_comb begin
    bwe = 1'b0;
    bwa = fill;
    bwd = cmd.data_byte;
    case (state)
      Q_IDLE: bwe = take && (cmd.command == sha256_pkg::CMD_DATA) && !done;
      Q_COMP: begin
        bwe = 1'b1;
        bwd = sha256_pkg::PAD_BYTE;
      end
      Q_PAD: begin
        bwe = 1'b1;
        if (fill >= sha256_pkg::LEN_POS && !second) bwd = bits[{~fill[2:0], 3'b111} -: 8];
        else bwd = 8'h00;
      end
      default: ;
    endcase
  end

  // second: block in pad needs full zero tail (0x80 landed at 56..62)
  logic dig_free;
  logic emit;
  logic start_now;
  assign dig_free = !dig.valid || dig.ready;
  assign emit = (state == Q_EMIT) && rd_pend && dig_free;
  assign start_now = (take && (cmd.command == sha256_pkg::CMD_DATA) && !done &&
                      (fill == 6'd63)) ||
                     (((state == Q_COMP) || (state == Q_PAD)) && (fill == 6'd63));

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.start <= 1'b0;
      reinit <= 1'b0;
    end else begin
      ctl.start <= start_now;
      reinit <= take && (cmd.command == sha256_pkg::CMD_RESTART);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Q_IDLE;
      fill <= '0;
      count <= '0;
      done <= 1'b0;
      dig.valid <= 1'b0;
      second <= 1'b0;
      widx <= '0;
      rd_pend <= 1'b0;
    end else begin
      case (state)
        Q_IDLE: begin
          if (take) begin
            case (cmd.command)
              sha256_pkg::CMD_DATA: if (!done) begin
                count <= count + 61'd1;
                fill <= fill + 6'd1;
                if (fill == 6'd63) state <= Q_WAIT;
              end
              sha256_pkg::CMD_FINISH: begin
                widx <= '0;
                rd_pend <= 1'b0;
                if (done) state <= Q_EMIT;
                else state <= Q_COMP;
              end
              sha256_pkg::CMD_RESTART: begin
                fill <= '0;
                count <= '0;
                done <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        Q_COMP: begin
          // write the 0x80 marker
          second <= (fill >= 6'd56) && (fill != 6'd63);
          fill <= fill + 6'd1;
          state <= (fill == 6'd63) ? Q_WAIT : Q_PAD;
        end
        Q_PAD: begin
          fill <= fill + 6'd1;
          if (fill == 6'd63) begin
            state <= Q_WAIT;
            if (second) second <= 1'b0;
            else done <= 1'b1;
          end
        end
        Q_WAIT: begin
          if (!ctl.start && !sts.busy) begin
            if (done) begin
              state <= Q_EMIT;
              widx <= '0;
              rd_pend <= 1'b0;
            end else if (fill == 6'd0 && count != '0 && !done && second == 1'b0
                         && last_pad) begin
              state <= Q_PAD;
            end else state <= Q_IDLE;
          end
        end
        Q_EMIT: begin
          if (dig_free) begin
            rd_pend <= !rd_pend;
            if (rd_pend) begin
              widx <= widx + 3'd1;
              if (widx == 3'd7) state <= Q_IDLE;
            end
          end
        end
        default: state <= Q_IDLE;
      endcase
      if (emit) dig.valid <= 1'b1;
      else if (dig.ready) dig.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      dig.digest_word <= hash_rdata;
      dig.word_index <= widx;
      dig.last_word <= (widx == 3'd7);
    end
  end

  // last_pad: a full block was just compressed during finish, pad another
  always_ff @(posedge clk) begin
    if (rst) last_pad <= 1'b0;
    else if (state == Q_COMP) last_pad <= (fill == 6'd63) || (fill >= 6'd56);
    else if (state == Q_PAD && fill == 6'd63 && second) last_pad <= 1'b1;
    else if (state == Q_WAIT && !ctl.start && !sts.busy) last_pad <= 1'b0;
    else if (state == Q_IDLE) last_pad <= 1'b0;
  end

  assert property (@(posedge clk) disable iff (rst) take |-> !sts.busy)
    else $error("item taken while compressing");
  assert property (@(posedge clk) disable iff (rst) ctl.start |=> sts.busy)
    else $error("core did not start");
  assert property (@(posedge clk) disable iff (rst)
    dig.valid && dig.last_word |-> dig.word_index == 3'd7)
    else $error("last marker misplaced");

endmodule
